### sv/mexp_pkg.sv
// shared constants and controller/datapath interface types
// for the modular exponentiation block; no dependencies
package mexp_pkg;

    localparam int MOD_BITS_DEF = 31;
    localparam int EXP_BITS_DEF = 32;
    localparam int RES_W        = 31;
    localparam int BASE_W       = 32;
    localparam int EXPIN_W      = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [31:0] MOD_RESET = 32'd1000000007;

    // word index of the modulus register (paddr[2])
    localparam logic REG_MODULUS = 1'b0;

    localparam logic FUNC_POWER   = 1'b0;
    localparam logic FUNC_INVERSE = 1'b1;

    typedef struct packed {
        logic load_item;
        logic mul_load;
        logic mul_acc;
        logic red_step;
        logic wr_acc;
        logic wr_sq;
        logic shift_exp;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic red_last;
        logic exp_zero;
        logic exp_lsb;
        logic mod_small;
        logic out_busy;
    } dp_stat_t;

endpackage

### sv/mexp_dp.sv
// datapath: accumulator, square, exponent, multiplier and shift-subtract reducer,
// plus the output register; driven by mexp_ctrl, uses mexp_pkg
module mexp_dp #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF,
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mexp_pkg::dp_cmd_t            cmd,
    output mexp_pkg::dp_stat_t           stat,
    input  logic [MOD_BITS-1:0]          modulus,
    input  logic                         in_func,
    input  logic [mexp_pkg::BASE_W-1:0]  in_base,
    input  logic [mexp_pkg::EXPIN_W-1:0] in_exp,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [mexp_pkg::RES_W-1:0]   out_result
);

    localparam int PROD_W = 2 * MOD_BITS;
    localparam int RED_W  = (PROD_W > mexp_pkg::BASE_W) ? PROD_W : mexp_pkg::BASE_W;
    localparam int CNT_W  = $clog2(RED_W);

    logic [MOD_BITS-1:0]        acc_reg;
    logic [MOD_BITS-1:0]        sq_reg;
    logic [EXP_BITS-1:0]        exp_reg;
    logic [RED_W-1:0]           div_reg;
    logic [MOD_BITS-1:0]        rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       out_valid_reg;
    logic [mexp_pkg::RES_W-1:0] out_data_reg;

    logic [MOD_BITS:0]          trial;
    logic [MOD_BITS:0]          trial_sub;
    logic [MOD_BITS-1:0]        rem_step;
    logic [MOD_BITS-1:0]        mul_a;
    logic [PROD_W-1:0]          prod;
    logic [MOD_BITS-1:0]        mod_m2;
    logic [63:0]                exp_wide;
    logic                       mod_small;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign trial     = {rem_reg, div_reg[RED_W-1]};
    assign trial_sub = trial - {1'b0, modulus};
    assign rem_step  = (trial >= {1'b0, modulus}) ? trial_sub[MOD_BITS-1:0]
                                                  : trial[MOD_BITS-1:0];

    assign mul_a = cmd.mul_acc ? acc_reg : sq_reg;
    assign prod  = PROD_W'(mul_a) * PROD_W'(sq_reg);

    // inverse by fermat: exponent is modulus minus two
    assign mod_m2    = modulus - MOD_BITS'(2);
    assign exp_wide  = (in_func == mexp_pkg::FUNC_INVERSE) ? 64'(mod_m2) : 64'(in_exp);
    assign mod_small = (modulus < MOD_BITS'(2));

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            acc_reg <= MOD_BITS'(1);
            exp_reg <= exp_wide[EXP_BITS-1:0];
            div_reg <= RED_W'(in_base);
            rem_reg <= '0;
        end
        else
        begin
            if (cmd.mul_load)
            begin
                div_reg <= RED_W'(prod);
                rem_reg <= '0;
            end
            else if (cmd.red_step)
            begin
                div_reg <= {div_reg[RED_W-2:0], 1'b0};
                rem_reg <= rem_step;
            end
            if (cmd.wr_acc)
            begin
                acc_reg <= rem_step;
            end
            if (cmd.shift_exp)
            begin
                exp_reg <= exp_reg >> 1;
            end
        end
        if (cmd.wr_sq)
        begin
            sq_reg <= rem_step;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= mod_small ? '0 : mexp_pkg::RES_W'(acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item || cmd.mul_load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.red_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.red_last  = (cnt_reg == CNT_W'(RED_W - 1));
    assign stat.exp_zero  = (exp_reg == '0);
    assign stat.exp_lsb   = exp_reg[0];
    assign stat.mod_small = mod_small;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;

endmodule

### sv/mexp_ctrl.sv
// controller state machine sequencing base reduction and square-and-multiply
// steps; talks to mexp_dp through mexp_pkg command and status structs
module mexp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mexp_pkg::dp_stat_t stat,
    output mexp_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BASE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_REDA  = 3'd3;
    localparam logic [2:0] S_MULS  = 3'd4;
    localparam logic [2:0] S_REDS  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_BASE;
                end
            end
            S_BASE:
            begin
                cmd.red_step = 1'b1;
                if (stat.red_last)
                begin
                    cmd.wr_sq  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.mod_small || stat.exp_zero)
                begin
                    state_next = S_DONE;
                end
                else if (stat.exp_lsb)
                begin
                    cmd.mul_load = 1'b1;
                    cmd.mul_acc  = 1'b1;
                    state_next   = S_REDA;
                end
                else
                begin
                    cmd.mul_load = 1'b1;
                    state_next   = S_REDS;
                end
            end
            S_REDA:
            begin
                cmd.red_step = 1'b1;
                if (stat.red_last)
                begin
                    cmd.wr_acc = 1'b1;
                    state_next = S_MULS;
                end
            end
            S_MULS:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_REDS;
            end
            S_REDS:
            begin
                cmd.red_step = 1'b1;
                if (stat.red_last)
                begin
                    cmd.wr_sq     = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/modular_exponentiation.sv
// one request at a time: the base is reduced, then square-and-multiply runs over the exponent bits,
// each reduction taking max(2*MOD_BITS, 32) shift-subtract steps (62 at defaults)
// the longest run is at default widths with all 32 exponent bits set, and its length is set by the reducer
// a new request is taken while the previous result waits in the output register
// async active-low reset: idle, output empty, modulus back to 1000000007
// top level: apb modulus register, controller and datapath; uses mexp_pkg
module modular_exponentiation #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF,
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // base_value[31:0], exponent[63:32]
    input  logic [0:0]                      s_tuser,   // func[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // result_value[30:0], zero[31]
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mexp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mexp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mexp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [MOD_BITS-1:0]        modulus_reg;
    logic                       reg_wr;
    mexp_pkg::dp_cmd_t          cmd;
    mexp_pkg::dp_stat_t         stat;
    logic [mexp_pkg::RES_W-1:0] result;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == mexp_pkg::REG_MODULUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mexp_pkg::MOD_RESET[MOD_BITS-1:0];
        end
        else if (reg_wr)
        begin
            modulus_reg <= pwdata[MOD_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == mexp_pkg::REG_MODULUS)
                  ? mexp_pkg::APB_DATA_W'(modulus_reg) : '0;

    mexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mexp_dp #(
        .MOD_BITS (MOD_BITS),
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .modulus    (modulus_reg),
        .in_func    (s_tuser[0]),
        .in_base    (s_tdata[31:0]),
        .in_exp     (s_tdata[63:32]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (result)
    );

    assign m_tdata = {1'b0, result};

endmodule

### sv/mexp_check.sv
// port-level checks for modular_exponentiation, attached by bind
// sees only the top level's ports
module mexp_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one request at a time: busy right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // padding bit above result_value stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31] == 1'b0)
        else $error("padding bit set");

    // a request accepted while the output is free does not produce a result straight away
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (!m_tvalid || m_tready) |=> ##1 !m_tvalid)
        else $error("result appeared too early");

endmodule

bind modular_exponentiation mexp_check u_check (.*);

### bench/modular_exponentiation_tb.sv
// self-checking bench for modular_exponentiation: stream requests in, results out, apb modulus
// predicts base^exponent mod modulus (power and fermat inverse) and checks every result in order
// depends on mexp_pkg and the modular_exponentiation top level
module modular_exponentiation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT   = 31;
    localparam int DRAIN_TAIL = 4200;

    localparam logic [mexp_pkg::APB_ADDR_W-1:0] ADDR_MODULUS = {mexp_pkg::REG_MODULUS, 2'b00};
    localparam logic [mexp_pkg::APB_ADDR_W-1:0] ADDR_UNUSED  = {~mexp_pkg::REG_MODULUS, 2'b00};

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [63:0]                     s_tdata;   // base_value[31:0], exponent[63:32]
    logic [0:0]                      s_tuser;   // func[0]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;   // result_value[30:0], zero[31]
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mexp_pkg::APB_ADDR_W-1:0] paddr;
    logic [mexp_pkg::APB_DATA_W-1:0] pwdata;
    logic [mexp_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    logic [30:0] modulus_shadow;
    logic [30:0] pending_powers[$];
    int          mismatch_count;
    bit          src_idle_on;
    bit          sink_idle_on;
    int          sink_hold_len;

    modular_exponentiation dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // right-to-left square and multiply over all exponent bits
    function automatic logic [30:0] modexp_predict(logic f, logic [31:0] b, logic [31:0] e,
                                                   logic [30:0] m);
        bit [63:0] mm;
        bit [63:0] ee;
        bit [63:0] acc;
        bit [63:0] sq;
        mm = m;
        if (mm < 64'd2)
            return '0;
        ee  = (f == mexp_pkg::FUNC_INVERSE) ? mm - 64'd2 : {32'd0, e};
        acc = 64'd1;
        sq  = {32'd0, b} % mm;
        for (int i = 0; i < mexp_pkg::EXP_BITS_DEF; i++)
        begin
            if (ee[i])
                acc = (acc * sq) % mm;
            sq = (sq * sq) % mm;
        end
        return acc[30:0];
    endfunction

    // mostly uniform, with some weight on the ends of the range
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'($urandom_range(0, 3));
            1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic f, input logic [31:0] b, input logic [31:0] e);
        while (src_idle_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {e, b};
        s_tuser  <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_powers.push_back(modexp_predict(f, b, e, modulus_shadow));
    endtask

    task automatic wait_drained(input int tail);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_powers.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic apb_write(input logic [mexp_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_MODULUS)
            modulus_shadow = data[30:0];
        @(posedge clk);
    endtask

    task automatic check_modulus_readback();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MODULUS;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[30:0] !== modulus_shadow)
        begin
            $error("modulus readback mismatch: expected %0d, actual %0d",
                   modulus_shadow, got[30:0]);
            mismatch_count++;
        end
        @(posedge clk);
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        int         hold_left;
        logic [30:0] want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_powers.size() == 0)
                begin
                    $error("result_value with no request outstanding: actual %0d",
                           m_tdata[30:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_powers.pop_front();
                    if (m_tdata[30:0] !== want)
                    begin
                        $error("result_value mismatch: expected %0d, actual %0d",
                               want, m_tdata[30:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[31] !== 1'b0)
                    begin
                        $error("pad bit mismatch: expected 0, actual %b", m_tdata[31]);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left == 0 && sink_hold_len > 0)
            begin
                hold_left     = sink_hold_len;
                sink_hold_len = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 99) < IDLE_PCT)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    task automatic test_reset_modulus();
        check_modulus_readback();
        send_request(mexp_pkg::FUNC_POWER, 32'd0, 32'd0);
        send_request(mexp_pkg::FUNC_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(mexp_pkg::FUNC_INVERSE, 32'd12345, $urandom);
        send_request(mexp_pkg::FUNC_POWER, 32'd2, 32'd10);
        wait_drained(2);
    endtask

    task automatic test_modulus_extremes();
        // largest modulus, which is also prime
        apb_write(ADDR_MODULUS, 32'h7FFF_FFFF);
        check_modulus_readback();
        send_request(mexp_pkg::FUNC_POWER, 32'hFFFF_FFFF, 32'd1);
        send_request(mexp_pkg::FUNC_INVERSE, 32'hFFFF_FFFF, $urandom);
        send_request(mexp_pkg::FUNC_POWER, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
        send_request(mexp_pkg::FUNC_INVERSE, 32'd0, 32'd0);
        wait_drained(2);
        // smallest legal modulus: inverse exponent is zero
        apb_write(ADDR_MODULUS, 32'd2);
        send_request(mexp_pkg::FUNC_INVERSE, 32'd0, $urandom);
        send_request(mexp_pkg::FUNC_INVERSE, 32'd1, $urandom);
        send_request(mexp_pkg::FUNC_POWER, 32'd3, 32'd0);
        wait_drained(2);
    endtask

    task automatic test_degenerate_modulus();
        apb_write(ADDR_MODULUS, 32'd0);
        send_request(mexp_pkg::FUNC_POWER, 32'd5, 32'd3);
        send_request(mexp_pkg::FUNC_INVERSE, 32'd5, 32'd0);
        wait_drained(2);
        apb_write(ADDR_MODULUS, 32'd1);
        send_request(mexp_pkg::FUNC_POWER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(mexp_pkg::FUNC_INVERSE, 32'd7, 32'd7);
        wait_drained(2);
        // composite modulus, inverse formula still applied
        apb_write(ADDR_MODULUS, 32'd1000);
        send_request(mexp_pkg::FUNC_INVERSE, 32'd3, 32'd0);
        send_request(mexp_pkg::FUNC_POWER, 32'd10, 32'd3);
        wait_drained(2);
    endtask

    task automatic test_register_decode();
        // top bit of the write data is dropped
        apb_write(ADDR_MODULUS, 32'h8000_0005);
        check_modulus_readback();
        send_request(mexp_pkg::FUNC_POWER, 32'd2, 32'd4);
        send_request(mexp_pkg::FUNC_INVERSE, 32'd2, $urandom);
        wait_drained(2);
        // write outside the register map leaves the modulus alone
        apb_write(ADDR_UNUSED, 32'd77);
        check_modulus_readback();
        send_request(mexp_pkg::FUNC_POWER, 32'd3, 32'd1);
        wait_drained(2);
    endtask

    task automatic test_random_sweeps();
        logic [31:0] mod_choice[5];
        mod_choice[0] = 32'h7FFF_FFFF;
        mod_choice[1] = $urandom;
        mod_choice[2] = 32'($urandom_range(2, 64));
        mod_choice[3] = mexp_pkg::MOD_RESET;
        mod_choice[4] = 32'($urandom_range(2, 32'h7FFF_FFFF));
        for (int p = 0; p < 5; p++)
        begin
            apb_write(ADDR_MODULUS, mod_choice[p]);
            // one phase runs with both sides streaming flat out
            src_idle_on  = (p != 2);
            sink_idle_on = (p != 2);
            for (int n = 0; n < 23; n++)
                send_request(logic'($urandom_range(0, 1)), rand_operand(), rand_operand());
            wait_drained(2);
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        apb_write(ADDR_MODULUS, $urandom);
        // short exponents so the block fills quickly behind the stalled output
        sink_hold_len = 4000;
        for (int n = 0; n < 6; n++)
            send_request(mexp_pkg::FUNC_POWER, $urandom, 32'($urandom_range(0, 15)));
        wait_drained(2);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        modulus_shadow = mexp_pkg::MOD_RESET[30:0];
        mismatch_count = 0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        sink_hold_len  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_modulus();
        test_modulus_extremes();
        test_degenerate_modulus();
        test_register_decode();
        test_backpressure();
        test_random_sweeps();

        wait_drained(DRAIN_TAIL);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #(80_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
